// File: hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/uti_pkg.sv
// Shared types and constants of the uniform table interpolator.
package uti_pkg;

   localparam int TABLE_DEPTH_DEF = 1024;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int DATA_W          = 32;
   localparam int LOAD_IDX_W      = 10;
   localparam int SCOUNT_W        = 11;
   localparam int PADDR_W         = 4;

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef enum logic [1:0] {
      REG_RANGE_START  = 2'd0,
      REG_INV_SPACING  = 2'd1,
      REG_SAMPLE_COUNT = 2'd2,
      REG_INTERP_MODE  = 2'd3
   } reg_idx_type;

   typedef struct packed {
      logic [DATA_W-1:0]   range_start;
      logic [DATA_W-1:0]   inv_spacing;
      logic [SCOUNT_W-1:0] sample_count;
      logic                interp_mode;
   } cfg_type;

endpackage

// File: hdl/uti_csr.sv
// Register file of the interpolator behind an APB-style port.
module uti_csr #(
   parameter int FRAC_BITS = uti_pkg::FRAC_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [uti_pkg::PADDR_W-1:0] paddr,
   input  logic [uti_pkg::DATA_W-1:0] pwdata,
   output logic [uti_pkg::DATA_W-1:0] prdata,
   output logic                       pready,
   output uti_pkg::cfg_type           cfg
);

   uti_pkg::cfg_type     cfg_ff;
   uti_pkg::cfg_type     cfg_in;
   uti_pkg::reg_idx_type reg_idx;
   logic                 wr_hit;

   assign reg_idx = uti_pkg::reg_idx_type'(paddr[3:2]);
   assign wr_hit  = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_hit) begin
         unique case (reg_idx)
            uti_pkg::REG_RANGE_START:  cfg_in.range_start  = pwdata;
            uti_pkg::REG_INV_SPACING:  cfg_in.inv_spacing  = pwdata;
            uti_pkg::REG_SAMPLE_COUNT: cfg_in.sample_count = pwdata[uti_pkg::SCOUNT_W-1:0];
            uti_pkg::REG_INTERP_MODE:  cfg_in.interp_mode  = pwdata[0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         uti_pkg::REG_RANGE_START:  prdata = cfg_ff.range_start;
         uti_pkg::REG_INV_SPACING:  prdata = cfg_ff.inv_spacing;
         uti_pkg::REG_SAMPLE_COUNT: prdata = uti_pkg::DATA_W'(cfg_ff.sample_count);
         uti_pkg::REG_INTERP_MODE:  prdata = uti_pkg::DATA_W'(cfg_ff.interp_mode);
         default:                   prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.range_start  <= '0;
         cfg_ff.inv_spacing  <= uti_pkg::DATA_W'(1) << FRAC_BITS;
         cfg_ff.sample_count <= uti_pkg::SCOUNT_W'(2);
         cfg_ff.interp_mode  <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: hdl/uti_sample_ram.sv
// Sample table: three copies written together, each read at its own address.
module uti_sample_ram #(
   parameter int DEPTH = uti_pkg::TABLE_DEPTH_DEF,
   parameter int IDX_W = $clog2(DEPTH)
) (
   input  logic                       clock,
   input  logic                       en,
   input  logic                       wr_en,
   input  logic [IDX_W-1:0]           wr_addr,
   input  logic [uti_pkg::DATA_W-1:0] wr_data,
   input  logic [IDX_W-1:0]           rd_addr0,
   input  logic [IDX_W-1:0]           rd_addr1,
   input  logic [IDX_W-1:0]           rd_addr2,
   output logic [uti_pkg::DATA_W-1:0] rd_data0,
   output logic [uti_pkg::DATA_W-1:0] rd_data1,
   output logic [uti_pkg::DATA_W-1:0] rd_data2
);

   logic [uti_pkg::DATA_W-1:0] bank0_ff [DEPTH];
   logic [uti_pkg::DATA_W-1:0] bank1_ff [DEPTH];
   logic [uti_pkg::DATA_W-1:0] bank2_ff [DEPTH];
   logic [uti_pkg::DATA_W-1:0] rd0_ff;
   logic [uti_pkg::DATA_W-1:0] rd1_ff;
   logic [uti_pkg::DATA_W-1:0] rd2_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         bank0_ff[wr_addr] <= wr_data;
         bank1_ff[wr_addr] <= wr_data;
         bank2_ff[wr_addr] <= wr_data;
      end
      if (en) begin
         rd0_ff <= bank0_ff[rd_addr0];
         rd1_ff <= bank1_ff[rd_addr1];
         rd2_ff <= bank2_ff[rd_addr2];
      end
   end

   assign rd_data0 = rd0_ff;
   assign rd_data1 = rd1_ff;
   assign rd_data2 = rd2_ff;

endmodule

// File: hdl/uniform_table_interpolator_core.sv
// Top level of the uniform table interpolator: eight-stage query pipeline.
// A query passes through the stage registers and shows its result on rsp_valid.
// Throughput: one request per cycle while req_stall is low; any mix of loads and queries streams.
// A load writes the table from the stage-2 registers, in order with queries.
// A stalled result freezes every stage; req_stall follows it in that cycle.
// Reset clears valid bits and configuration registers; payload registers and table contents stay undefined.
module uniform_table_interpolator_core #(
   parameter int TABLE_DEPTH = uti_pkg::TABLE_DEPTH_DEF,
   parameter int FRAC_BITS   = uti_pkg::FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_type,
   input  logic [uti_pkg::LOAD_IDX_W-1:0] req_load_index,
   input  logic signed [uti_pkg::DATA_W-1:0] req_sample_value,
   input  logic signed [uti_pkg::DATA_W-1:0] req_query_x,
   // result channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [uti_pkg::DATA_W-1:0] rsp_interp_value,
   output logic                           rsp_out_of_range,
   // configuration port
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [uti_pkg::PADDR_W-1:0]    paddr,
   input  logic [uti_pkg::DATA_W-1:0]     pwdata,
   output logic [uti_pkg::DATA_W-1:0]     prdata,
   output logic                           pready
);

   localparam int DW   = uti_pkg::DATA_W;
   localparam int IW   = $clog2(TABLE_DEPTH);
   localparam int PW   = 2 * DW - FRAC_BITS;     // grid position width
   localparam int AW   = DW + 4;                 // A2, B2 and slope width
   localparam int P1W  = AW + FRAC_BITS + 1;
   localparam int CW   = AW + 2;                 // quadratic coefficient c
   localparam int P2W  = CW + FRAC_BITS + 1;
   localparam int YW   = CW + 1;
   localparam logic signed [P1W-1:0] RND1 = P1W'(1) << (FRAC_BITS - 1);
   localparam logic signed [P2W-1:0] RND2 = P2W'(1) << FRAC_BITS;

   uti_pkg::cfg_type cfg;

   // The whole pipeline moves together; hold everything while a result waits.
   logic adv;
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   uti_csr #(.FRAC_BITS(FRAC_BITS)) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // ---------------- stage 1: offset from the first abscissa ----------------
   logic                           s1_valid_ff;
   logic                           s1_query_ff;
   logic [uti_pkg::LOAD_IDX_W-1:0] s1_idx_ff;
   logic [DW-1:0]                  s1_val_ff;
   logic signed [DW:0]             s1_diff_ff;
   logic signed [DW:0]             s1_diff_in;

   assign s1_diff_in = $signed({req_query_x[DW-1], req_query_x})
                     - $signed({cfg.range_start[DW-1], cfg.range_start});

   // ---------------- stage 2: scale by the reciprocal spacing ----------------
   logic                           s2_valid_ff;
   logic                           s2_query_ff;
   logic [uti_pkg::LOAD_IDX_W-1:0] s2_idx_ff;
   logic [DW-1:0]                  s2_val_ff;
   logic                           s2_neg_ff;
   logic [PW-1:0]                  s2_pos_ff;
   logic [2*DW-1:0]                s2_prod_in;

   assign s2_prod_in = (2*DW)'(s1_diff_ff[DW-1:0]) * (2*DW)'(cfg.inv_spacing);

   // ---------------- stage 3: classify, address and access the table ----------------
   logic [31:0]    n_w;
   logic [31:0]    sc_w;
   logic [IW-1:0]  nm1_w;
   logic [PW-1:0]  last_pos_w;
   logic           above_w;
   logic           clamp_w;
   logic [IW-1:0]  i_w;
   logic [FRAC_BITS-1:0] t_w;
   logic           quad_w;
   logic           qz_w;
   logic [IW-1:0]  a0_w;
   logic [IW-1:0]  a1_w;
   logic [IW-1:0]  a2_w;
   logic [31:0]    ld_ext_w;
   logic           wr_en_w;

   assign sc_w = 32'(cfg.sample_count);

   always_comb begin
      if (sc_w < 32'd2) begin
         n_w = 32'd2;
      end else if (sc_w > 32'(TABLE_DEPTH)) begin
         n_w = 32'(TABLE_DEPTH);
      end else begin
         n_w = sc_w;
      end
   end

   assign nm1_w      = IW'(n_w - 32'd1);
   assign last_pos_w = PW'(n_w - 32'd1) << FRAC_BITS;
   assign above_w    = !s2_neg_ff && (s2_pos_ff > last_pos_w);
   assign clamp_w    = s2_neg_ff || (s2_pos_ff >= last_pos_w);
   assign i_w        = s2_pos_ff[FRAC_BITS +: IW];
   assign t_w        = s2_pos_ff[FRAC_BITS-1:0];
   // Two samples cannot carry a parabola; fall back to linear.
   assign quad_w     = cfg.interp_mode && (n_w >= 32'd3);
   // First interval takes the one-sided form through points 0, 1 and 2.
   // Clamped queries never use it: their interval bits are meaningless.
   assign qz_w       = quad_w && !clamp_w && (i_w == '0);

   always_comb begin
      if (qz_w) begin
         a0_w = '0;
         a1_w = IW'(1);
         a2_w = IW'(2);
      end else begin
         a0_w = i_w - IW'(1);
         a1_w = i_w;
         a2_w = i_w + IW'(1);
      end
      // Clamped queries read the end sample through the middle bank.
      if (s2_neg_ff) begin
         a1_w = '0;
      end else if (clamp_w) begin
         a1_w = nm1_w;
      end
   end

   // Drop loads aimed beyond the table.
   assign ld_ext_w = 32'(s2_idx_ff);
   assign wr_en_w  = adv && s2_valid_ff && (s2_query_ff == uti_pkg::REQ_LOAD)
                   && (ld_ext_w < 32'(TABLE_DEPTH));

   logic [DW-1:0] d0_w;
   logic [DW-1:0] d1_w;
   logic [DW-1:0] d2_w;

   uti_sample_ram #(.DEPTH(TABLE_DEPTH), .IDX_W(IW)) u_ram (
      .clock    (clock),
      .en       (adv),
      .wr_en    (wr_en_w),
      .wr_addr  (ld_ext_w[IW-1:0]),
      .wr_data  (s2_val_ff),
      .rd_addr0 (a0_w),
      .rd_addr1 (a1_w),
      .rd_addr2 (a2_w),
      .rd_data0 (d0_w),
      .rd_data1 (d1_w),
      .rd_data2 (d2_w)
   );

   logic                 s3_valid_ff;
   logic                 s3_clamp_ff;
   logic                 s3_oor_ff;
   logic                 s3_quad_ff;
   logic                 s3_qz_ff;
   logic [FRAC_BITS-1:0] s3_t_ff;

   // ---------------- stage 4: A2 term, second difference and slope ----------------
   logic signed [AW-1:0] e0_w;
   logic signed [AW-1:0] e1_w;
   logic signed [AW-1:0] e2_w;
   logic signed [AW-1:0] a2c_w;
   logic signed [AW-1:0] b2c_w;
   logic signed [AW-1:0] dl_w;

   assign e0_w  = AW'($signed(d0_w));
   assign e1_w  = AW'($signed(d1_w));
   assign e2_w  = AW'($signed(d2_w));
   assign a2c_w = s3_qz_ff ? (4 * e1_w - 3 * e0_w - e2_w) : (e2_w - e0_w);
   assign b2c_w = e2_w - 2 * e1_w + e0_w;
   assign dl_w  = e2_w - e1_w;

   logic                 s4_valid_ff;
   logic                 s4_clamp_ff;
   logic                 s4_oor_ff;
   logic                 s4_quad_ff;
   logic [FRAC_BITS-1:0] s4_t_ff;
   logic signed [DW-1:0] s4_yi_ff;
   logic signed [AW-1:0] s4_a2_ff;
   logic signed [AW-1:0] s4_mop_ff;

   // ---------------- stage 5: first product ----------------
   logic signed [P1W-1:0] s5_prod_in;
   assign s5_prod_in = P1W'(s4_mop_ff) * P1W'($signed({1'b0, s4_t_ff}));

   logic                  s5_valid_ff;
   logic                  s5_clamp_ff;
   logic                  s5_oor_ff;
   logic                  s5_quad_ff;
   logic [FRAC_BITS-1:0]  s5_t_ff;
   logic signed [DW-1:0]  s5_yi_ff;
   logic signed [AW-1:0]  s5_a2_ff;
   logic signed [P1W-1:0] s5_prod_ff;

   // ---------------- stage 6: round; linear result or coefficient c ----------------
   logic signed [P1W-1:0] r1_w;
   logic signed [CW-1:0]  s6_c_in;

   assign r1_w    = (s5_prod_ff + RND1) >>> FRAC_BITS;
   assign s6_c_in = s5_quad_ff ? (CW'(s5_a2_ff) + CW'(r1_w))
                               : (CW'(s5_yi_ff) + CW'(r1_w));

   logic                 s6_valid_ff;
   logic                 s6_clamp_ff;
   logic                 s6_oor_ff;
   logic                 s6_quad_ff;
   logic [FRAC_BITS-1:0] s6_t_ff;
   logic signed [DW-1:0] s6_yi_ff;
   logic signed [CW-1:0] s6_c_ff;

   // ---------------- stage 7: second product ----------------
   logic signed [P2W-1:0] s7_prod_in;
   assign s7_prod_in = P2W'(s6_c_ff) * P2W'($signed({1'b0, s6_t_ff}));

   logic                  s7_valid_ff;
   logic                  s7_clamp_ff;
   logic                  s7_oor_ff;
   logic                  s7_quad_ff;
   logic signed [DW-1:0]  s7_yi_ff;
   logic signed [CW-1:0]  s7_c_ff;
   logic signed [P2W-1:0] s7_prod_ff;

   // ---------------- stage 8: final add and saturate ----------------
   logic signed [P2W-1:0] r2_w;
   logic signed [YW-1:0]  yq_w;
   logic signed [YW-1:0]  ysel_w;
   logic [DW-1:0]         ysat_w;

   assign r2_w = (s7_prod_ff + RND2) >>> (FRAC_BITS + 1);
   assign yq_w = YW'(s7_yi_ff) + YW'(r2_w);

   always_comb begin
      if (s7_clamp_ff) begin
         ysel_w = YW'(s7_yi_ff);
      end else if (s7_quad_ff) begin
         ysel_w = yq_w;
      end else begin
         ysel_w = YW'(s7_c_ff);
      end
      if ((ysel_w[YW-1:DW-1] == '0) || (ysel_w[YW-1:DW-1] == '1)) begin
         ysat_w = ysel_w[DW-1:0];
      end else if (ysel_w[YW-1]) begin
         ysat_w = {1'b1, {(DW-1){1'b0}}};
      end else begin
         ysat_w = {1'b0, {(DW-1){1'b1}}};
      end
   end

   logic          rsp_valid_ff;
   logic [DW-1:0] rsp_value_ff;
   logic          rsp_oor_ff;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_interp_value = rsp_value_ff;
   assign rsp_out_of_range = rsp_oor_ff;

   // Valid bits: cleared by reset, advanced with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         s6_valid_ff  <= 1'b0;
         s7_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= req_valid;
         s2_valid_ff  <= s1_valid_ff;
         // Loads end at the table write; only queries go on.
         s3_valid_ff  <= s2_valid_ff && (s2_query_ff == uti_pkg::REQ_QUERY);
         s4_valid_ff  <= s3_valid_ff;
         s5_valid_ff  <= s4_valid_ff;
         s6_valid_ff  <= s5_valid_ff;
         s7_valid_ff  <= s6_valid_ff;
         rsp_valid_ff <= s7_valid_ff;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_query_ff  <= req_type;
         s1_idx_ff    <= req_load_index;
         s1_val_ff    <= req_sample_value;
         s1_diff_ff   <= s1_diff_in;

         s2_query_ff  <= s1_query_ff;
         s2_idx_ff    <= s1_idx_ff;
         s2_val_ff    <= s1_val_ff;
         s2_neg_ff    <= s1_diff_ff[DW];
         s2_pos_ff    <= s2_prod_in[2*DW-1:FRAC_BITS];

         s3_clamp_ff  <= clamp_w;
         s3_oor_ff    <= s2_neg_ff || above_w;
         s3_quad_ff   <= quad_w;
         s3_qz_ff     <= qz_w;
         s3_t_ff      <= t_w;

         s4_clamp_ff  <= s3_clamp_ff;
         s4_oor_ff    <= s3_oor_ff;
         s4_quad_ff   <= s3_quad_ff;
         s4_t_ff      <= s3_t_ff;
         s4_yi_ff     <= s3_qz_ff ? d0_w : d1_w;
         s4_a2_ff     <= a2c_w;
         s4_mop_ff    <= s3_quad_ff ? b2c_w : dl_w;

         s5_clamp_ff  <= s4_clamp_ff;
         s5_oor_ff    <= s4_oor_ff;
         s5_quad_ff   <= s4_quad_ff;
         s5_t_ff      <= s4_t_ff;
         s5_yi_ff     <= s4_yi_ff;
         s5_a2_ff     <= s4_a2_ff;
         s5_prod_ff   <= s5_prod_in;

         s6_clamp_ff  <= s5_clamp_ff;
         s6_oor_ff    <= s5_oor_ff;
         s6_quad_ff   <= s5_quad_ff;
         s6_t_ff      <= s5_t_ff;
         s6_yi_ff     <= s5_yi_ff;
         s6_c_ff      <= s6_c_in;

         s7_clamp_ff  <= s6_clamp_ff;
         s7_oor_ff    <= s6_oor_ff;
         s7_quad_ff   <= s6_quad_ff;
         s7_yi_ff     <= s6_yi_ff;
         s7_c_ff      <= s6_c_ff;
         s7_prod_ff   <= s7_prod_in;

         rsp_value_ff <= ysat_w;
         rsp_oor_ff   <= s7_oor_ff;
      end
   end

endmodule

// File: hdl/uti_core_checker.sv
// Port-level checks of the interpolator core, bound to the top level.
`include "assert_macros.svh"

module uti_core_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [uti_pkg::DATA_W-1:0]     rsp_interp_value,
   input logic                           rsp_out_of_range,
   input logic                           psel,
   input logic                           penable,
   input logic                           pready
);

   `ASSERT_CLK(a_reset_empties, clock, reset |=> !rsp_valid, "result valid after reset")
   `ASSERT_CLK_RST(a_stall_follows, clock, reset, req_stall == (rsp_valid && rsp_stall), "request stall differs from held result")
   `ASSERT_CLK_RST(a_result_held, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_interp_value) && $stable(rsp_out_of_range), "stalled result changed")
   `ASSERT_CLK_RST(a_apb_ready, clock, reset, psel && penable |-> pready, "access without ready")

endmodule

bind uniform_table_interpolator_core uti_core_checker u_uti_core_checker (.*);

// File: dv/uniform_table_interpolator_core_tb.sv
// Self-checking testbench for the uniform table interpolator core.
module uniform_table_interpolator_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = uti_pkg::TABLE_DEPTH_DEF;
   localparam int FB = uti_pkg::FRAC_BITS_DEF;
   localparam longint CYCLE_LIMIT = 900000;

   typedef struct {
      logic signed [31:0] value;
      logic               clamped;
   } interp_result_type;

   // Tracks table, registers and outstanding results; predicts each query.
   class interp_scoreboard_type;
      logic signed [31:0] samples [DEPTH];
      logic [31:0]        x_origin;
      logic [31:0]        inv_step;
      logic [10:0]        count_reg;
      logic               quad_mode;
      interp_result_type  awaited [$];
      int                 failures;
      int                 checked;

      function new();
         x_origin = 0;
         inv_step = 32'h1 << FB;
         count_reg = 2;
         quad_mode = 0;
         failures = 0;
         checked = 0;
      endfunction

      function void set_register(uti_pkg::reg_idx_type idx, logic [31:0] val);
         case (idx)
            uti_pkg::REG_RANGE_START: x_origin = val;
            uti_pkg::REG_INV_SPACING: inv_step = val;
            uti_pkg::REG_SAMPLE_COUNT: count_reg = val[10:0];
            uti_pkg::REG_INTERP_MODE: quad_mode = val[0];
         endcase
      endfunction

      function longint round_shift(longint v, int s);
         return (v + (longint'(1) <<< (s - 1))) >>> s;
      endfunction

      function interp_result_type evaluate_query(logic signed [31:0] x);
         interp_result_type r;
         longint n, diff, y, yi, a2, b2, c, t, ym, yp, y0, y1, y2;
         logic [63:0] pos, last_pos, prod;
         longint unsigned i;
         n = count_reg;
         if (n < 2) n = 2;
         if (n > DEPTH) n = DEPTH;
         last_pos = 64'(n - 1) << FB;
         diff = longint'(x) - longint'($signed(x_origin));
         r.clamped = 0;
         if (diff < 0) begin
            y = samples[0];
            r.clamped = 1;
         end else begin
            prod = 64'(diff) * 64'(inv_step);
            pos = prod >> FB;
            if (pos >= last_pos) begin
               y = samples[n-1];
               r.clamped = (pos > last_pos);
            end else begin
               i = pos >> FB;
               t = longint'(pos[FB-1:0]);
               yi = samples[i];
               if (!quad_mode || n < 3) begin
                  y = yi + round_shift((longint'(samples[i+1]) - yi) * t, FB);
               end else begin
                  if (i == 0) begin
                     y0 = samples[0];
                     y1 = samples[1];
                     y2 = samples[2];
                     a2 = 4 * y1 - 3 * y0 - y2;
                     b2 = y2 - 2 * y1 + y0;
                  end else begin
                     ym = samples[i-1];
                     yp = samples[i+1];
                     a2 = yp - ym;
                     b2 = yp - 2 * yi + ym;
                  end
                  c = round_shift((a2 <<< FB) + b2 * t, FB);
                  y = yi + round_shift(c * t, FB + 1);
               end
            end
         end
         if (y > 64'sh7FFFFFFF) y = 64'sh7FFFFFFF;
         if (y < -64'sh80000000) y = -64'sh80000000;
         r.value = y[31:0];
         return r;
      endfunction

      function void note_request(logic kind, logic [9:0] idx, logic signed [31:0] val,
                                 logic signed [31:0] x);
         if (kind == uti_pkg::REQ_LOAD) samples[idx] = val;
         else awaited.push_back(evaluate_query(x));
      endfunction

      function void check_result(logic signed [31:0] val, logic clamped);
         interp_result_type e;
         if (awaited.size() == 0) begin
            $display("%0t: result with nothing outstanding: value %0d flag %0b",
                     $time, val, clamped);
            failures++;
            return;
         end
         e = awaited.pop_front();
         checked++;
         if (val !== e.value) begin
            $display("%0t: interp_value expected %0d actual %0d", $time, e.value, val);
            failures++;
         end
         if (clamped !== e.clamped) begin
            $display("%0t: out_of_range expected %0b actual %0b", $time, e.clamped, clamped);
            failures++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset;
   logic req_valid, req_stall, req_type;
   logic [uti_pkg::LOAD_IDX_W-1:0] req_load_index;
   logic signed [uti_pkg::DATA_W-1:0] req_sample_value, req_query_x;
   logic rsp_valid, rsp_stall, rsp_out_of_range;
   logic signed [uti_pkg::DATA_W-1:0] rsp_interp_value;
   logic psel, penable, pwrite, pready;
   logic [uti_pkg::PADDR_W-1:0] paddr;
   logic [uti_pkg::DATA_W-1:0] pwdata, prdata;

   interp_scoreboard_type sb = new();
   bit written [DEPTH];
   bit quiet;          // no idling on either side while set
   longint cycle_count = 0;
   int phase_count = 0;
   int n_eff;

   uniform_table_interpolator_core dut (.*);

   always #6 clock = ~clock;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // Watchdog: give up well past the slowest legal run.
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
   end

   // Result monitor: a result moves when valid is high and stall is low.
   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_interp_value, rsp_out_of_range);

   // Result stall generator: hold stall for a drawn count, then release for one result.
   initial begin
      int k;
      rsp_stall <= 1'b0;
      @(negedge reset);
      forever begin
         k = quiet ? 0 : $urandom_range(0, 17);
         if (k > 0) begin
            rsp_stall <= 1'b1;
            repeat (k) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Drive one request; return at the edge that accepted it.
   task automatic send_request(logic kind, logic [9:0] idx, logic [31:0] val,
                               logic [31:0] x);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_load_index <= idx;
      req_sample_value <= val;
      req_query_x <= x;
      do @(posedge clock); while (req_stall);
      sb.note_request(kind, idx, val, x);
      if (kind == uti_pkg::REQ_LOAD) written[idx] = 1;
   endtask

   task automatic load_sample(logic [9:0] idx, logic [31:0] val);
      send_request(uti_pkg::REQ_LOAD, idx, val, $urandom);
   endtask

   task automatic query_at(logic [31:0] x);
      send_request(uti_pkg::REQ_QUERY, 10'($urandom), $urandom, x);
   endtask

   // Register write with a setup and an access phase; the register takes the value at the access edge.
   task automatic write_register(uti_pkg::reg_idx_type idx, logic [31:0] val);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= uti_pkg::PADDR_W'(idx) << 2;
      pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      sb.set_register(idx, val);
   endtask

   // Drain outstanding results, then let the pipeline empty.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   function automatic logic [31:0] draw_sample();
      case ($urandom_range(0, 4))
         0: return $urandom;
         1: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
         2: return $urandom_range(0, 1 << 22) - (1 << 21);
         default: return $urandom_range(0, 1 << 26) - (1 << 25);
      endcase
   endfunction

   // Aim most queries inside the grid, some at knots, some past the ends.
   function automatic logic [31:0] draw_query();
      longint unsigned p, d;
      longint xs;
      if (sb.inv_step == 0 || $urandom_range(0, 9) < 2) return $urandom;
      p = $urandom_range(0, 99) < 15 ? (longint'($urandom_range(0, n_eff - 1)) << FB)
          : longint'($urandom) % ((longint'(n_eff - 1) << FB) + 64'd40000);
      d = ((p << FB) + sb.inv_step - 1) / sb.inv_step;
      if ($urandom_range(0, 3) == 0) d = (p << FB) / sb.inv_step;
      xs = longint'($signed(sb.x_origin)) + longint'(d);
      if (xs > 64'sh7FFFFFFF || xs < -64'sh80000000) return $urandom;
      return xs[31:0];
   endfunction

   // Configure one setting, make sure every entry in use is loaded, then stream.
   task automatic run_phase(logic [31:0] x0, logic [31:0] inv, logic [10:0] cnt,
                            logic mode, int items);
      settle();
      write_register(uti_pkg::REG_RANGE_START, x0);
      write_register(uti_pkg::REG_INV_SPACING, inv);
      write_register(uti_pkg::REG_SAMPLE_COUNT, 32'(cnt));
      write_register(uti_pkg::REG_INTERP_MODE, 32'(mode));
      n_eff = cnt < 2 ? 2 : (cnt > DEPTH ? DEPTH : cnt);
      phase_count++;
      for (int k = 0; k < n_eff; k++)
         if (!written[k]) load_sample(10'(k), draw_sample());
      for (int k = 0; k < items; k++) begin
         if ($urandom_range(0, 4) == 0)
            load_sample($urandom_range(0, 7) == 0 ? 10'($urandom_range(0, DEPTH - 1))
                        : 10'($urandom_range(0, n_eff - 1)), draw_sample());
         else query_at(draw_query());
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_type <= uti_pkg::REQ_LOAD;
      req_load_index <= '0;
      req_sample_value <= '0;
      req_query_x <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      quiet = 0;
      n_eff = 2;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset settings, two samples, both ends and the clamps.
      load_sample(0, 32'sh00010000);
      load_sample(1, 32'sh00050000);
      query_at(0);
      query_at(32'h00008000);
      query_at(32'h00010000);
      query_at(32'h00010001);
      query_at(32'hFFFFFFFF);
      query_at(32'h80000000);
      query_at(32'h7FFFFFFF);
      // Quadratic on three samples: one-sided first interval, centred last one.
      settle();
      run_phase(32'h80000000, 32'h00010000, 3, 1, 0);
      load_sample(0, 32'h7FFFFFFF);
      load_sample(1, 32'h80000000);
      load_sample(2, 32'h7FFFFFFF);
      query_at(32'h80004000);
      query_at(32'h8000C000);
      query_at(32'h80018000);
      query_at(32'h80020000);
      // Zero spacing, then too few samples asked for in quadratic and in linear mode.
      run_phase(32'h7FFFFFFF, 32'h0, 5, 1, 4);
      run_phase(32'h0, 32'hFFFFFFFF, 0, 1, 4);
      run_phase(32'h0, 32'h00008000, 1, 0, 4);
      load_sample(10'h3FF, 32'h12345678);

      // Count register past the depth: the full table is used; probe its top end.
      settle();
      write_register(uti_pkg::REG_RANGE_START, 32'h0);
      write_register(uti_pkg::REG_INV_SPACING, 32'h00010000);
      write_register(uti_pkg::REG_SAMPLE_COUNT, 32'h000007FF);
      write_register(uti_pkg::REG_INTERP_MODE, 32'h1);
      phase_count++;
      load_sample(10'd1021, draw_sample());
      load_sample(10'd1022, draw_sample());
      load_sample(10'd1023, draw_sample());
      query_at(32'h03FE8000);
      query_at(32'h03FF0000);
      query_at(32'h03FF0001);
      query_at(32'h80000000);

      // Random phases; three run with no idling at all.
      for (int ph = 0; ph < 14; ph++) begin
         logic [31:0] x0, inv;
         logic [10:0] cnt;
         x0 = $urandom_range(0, 2) == 0 ? $urandom : $urandom_range(0, 1 << 20) - (1 << 19);
         inv = $urandom_range(0, 1) ? $urandom_range(1 << 12, 1 << 20) : $urandom;
         cnt = 11'($urandom_range(2, 40));
         quiet = (ph % 5 == 2);
         run_phase(x0, inv, cnt, $urandom_range(0, 1), 70);
      end
      quiet = 0;
      settle();
      repeat (20) @(posedge clock);

      $display("Covered %0d register settings and %0d checked query results.",
               phase_count, sb.checked);
      $display("Linear and quadratic modes, clamped ends, zero and full-scale spacing.");
      if (sb.failures == 0 && sb.awaited.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end
endmodule
